// File: design/ffp_pkg.sv
// ----------------------------------------------------------------------------
// ffp_pkg
// Shared types and constants of the flame flicker pixel engine.
// ----------------------------------------------------------------------------
package ffp_pkg;

    // input item as captured at acceptance
    typedef struct packed {
        logic              kind;
        logic [4:0]        hue;
        logic signed [5:0] variation;
        logic [6:0]        gust_threshold;
        logic [7:0]        gust_target;
        logic [1:0]        gust_speed;
        logic signed [1:0] noise;
        logic [7:0]        recover_target;
        logic              last_pixel;
    } in_item_t;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] white;
        logic [7:0] level;
        logic       frame_end;
    } out_item_t;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic step1;
        logic step2;
        logic commit;
    } ctrl_cmd_t;

    typedef struct packed {
        logic       we;
        logic [7:0] index;
        logic [7:0] data;
    } cfg_wr_t;

    localparam logic KIND_WIND  = 1'b0;
    localparam logic KIND_PIXEL = 1'b1;

    localparam logic [7:0] CFG_FLAME_FLOOR   = 8'd0;
    localparam logic [7:0] CFG_FLAME_CEILING = 8'd1;
    localparam logic [7:0] CFG_GLOW_FLOOR    = 8'd2;
    localparam logic [7:0] CFG_GLOW_CEILING  = 8'd3;

    localparam logic [7:0] RST_FLAME_FLOOR   = 8'd30;
    localparam logic [7:0] RST_FLAME_CEILING = 8'd200;
    localparam logic [7:0] RST_GLOW_FLOOR    = 8'd110;
    localparam logic [7:0] RST_GLOW_CEILING  = 8'd240;
    localparam logic [7:0] RST_LEVEL         = 8'd90;
    localparam logic [1:0] RST_SPEED         = 2'd1;

    localparam logic [6:0] CALM_LIMIT = 7'd80;
    localparam logic [8:0] DIM_MARGIN = 9'd20;
    localparam logic [4:0] HUE_SPLIT  = 5'd10;

    localparam logic [1:0] SPEED_DIV10 = 2'd0;
    localparam logic [1:0] SPEED_DIV8  = 2'd1;
    localparam logic [1:0] SPEED_DIV6  = 2'd2;
    localparam logic [1:0] SPEED_DIV4  = 2'd3;

    // reciprocal multipliers, exact over the operand ranges used here
    localparam logic [15:0] RECIP_DIV10 = 16'd205;   // >> 11, x < 1029
    localparam logic [15:0] RECIP_DIV6  = 16'd171;   // >> 10, x < 512
    localparam logic [15:0] RECIP_WHITE = 16'd205;   // >> 12, x < 1024
    localparam logic [26:0] RECIP_LOW   = 27'd3277;  // >> 16, x < 16384
    localparam logic [26:0] RECIP_HIGH  = 27'd8739;  // >> 17, x < 10082

endpackage

// File: design/ffp_if.sv
// ----------------------------------------------------------------------------
// ffp interfaces
// Item, result and register write channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface ffp_item_if;
    logic              valid;
    logic              ready;
    logic              kind;
    logic [4:0]        hue;
    logic signed [5:0] variation;
    logic [6:0]        gust_threshold;
    logic [7:0]        gust_target;
    logic [1:0]        gust_speed;
    logic signed [1:0] noise;
    logic [7:0]        recover_target;
    logic              last_pixel;

    modport source (
        output valid, kind, hue, variation, gust_threshold, gust_target,
               gust_speed, noise, recover_target, last_pixel,
        input  ready
    );
    modport sink (
        input  valid, kind, hue, variation, gust_threshold, gust_target,
               gust_speed, noise, recover_target, last_pixel,
        output ready
    );
endinterface

interface ffp_result_if;
    logic       valid;
    logic       ready;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] white;
    logic [7:0] level;
    logic       frame_end;

    modport source (
        output valid, red, green, white, level, frame_end,
        input  ready
    );
    modport sink (
        input  valid, red, green, white, level, frame_end,
        output ready
    );
endinterface

interface ffp_cfg_if;
    logic       valid;
    logic       ready;
    logic [7:0] index;
    logic [7:0] data;

    modport source (
        output valid, index, data,
        input  ready
    );
    modport sink (
        input  valid, index, data,
        output ready
    );
endinterface

// File: design/ffp_ctrl.sv
// ----------------------------------------------------------------------------
// ffp_ctrl
// Sequencer: accept, three datapath steps, commit into the output register.
// ----------------------------------------------------------------------------
module ffp_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    output logic              out_valid,
    input  logic              out_ready,
    output ffp_pkg::ctrl_cmd_t cmd
);
    import ffp_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_STEP1 = 4'b0010,
        ST_STEP2 = 4'b0100,
        ST_STEP3 = 4'b1000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   out_free;

    assign out_free  = !out_valid_reg || out_ready;
    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd            = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_STEP1;
                end
            end
            ST_STEP1:
            begin
                cmd.step1  = 1'b1;
                state_next = ST_STEP2;
            end
            ST_STEP2:
            begin
                cmd.step2  = 1'b1;
                state_next = ST_STEP3;
            end
            ST_STEP3:
            begin
                // hold until the output register can take the result
                if (out_free)
                begin
                    cmd.commit     = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// File: design/ffp_dp.sv
// ----------------------------------------------------------------------------
// ffp_dp
// Datapath: flame state, registers, wind step and pixel colour arithmetic.
// ----------------------------------------------------------------------------
module ffp_dp (
    input  logic               clk,
    input  logic               rst_n,
    input  ffp_pkg::ctrl_cmd_t cmd,
    input  ffp_pkg::in_item_t  item_in,
    input  ffp_pkg::cfg_wr_t   cfg_wr,
    output ffp_pkg::out_item_t result_out
);
    import ffp_pkg::*;

    // configuration and flame state
    logic [7:0] flame_floor_reg;
    logic [7:0] flame_ceiling_reg;
    logic [7:0] glow_floor_reg;
    logic [7:0] glow_ceiling_reg;
    logic [7:0] global_reg;
    logic [7:0] filtered_reg;
    logic [7:0] goal_reg;
    logic [1:0] speed_reg;
    logic [7:0] tick_reg;
    logic [6:0] calm_reg;

    logic [7:0] global_next;
    logic [7:0] filtered_next;
    logic [7:0] goal_next;
    logic [1:0] speed_next;
    logic [7:0] tick_next;
    logic [6:0] calm_next;

    // payload pipeline registers
    in_item_t   item_reg;
    logic [7:0] abs_reg;
    logic       neg_reg;
    logic [7:0] b_reg;
    logic [5:0] q_reg;
    logic [12:0] prod_reg;
    logic [7:0] white_reg;
    logic       low_hue_reg;
    out_item_t  res_reg;

    logic [7:0] abs_next;
    logic       neg_next;
    logic [7:0] b_next;
    logic [5:0] q_next;
    logic [12:0] prod_next;
    logic [7:0] white_next;
    logic       low_hue_next;
    out_item_t  res_next;

    // step 1
    logic [7:0]        tick_inc;
    logic              gust;
    logic [7:0]        goal_sel;
    logic signed [8:0] gap;
    logic signed [8:0] gap_neg;
    logic signed [9:0] tgt_sum;
    logic signed [9:0] flame_lo;
    logic signed [9:0] flame_hi;
    logic [7:0]        tgt;
    logic [9:0]        b_sum;

    // step 2
    logic [15:0] q_prod;
    logic [15:0] q_full;
    logic [4:0]  hue_factor;
    logic [15:0] white_prod;

    // step 3
    logic signed [10:0] step_val;
    logic signed [10:0] g_sum;
    logic signed [10:0] glow_lo;
    logic signed [10:0] glow_hi;
    logic [7:0]         g_new;
    logic [8:0]         dim_limit;
    logic [6:0]         calm_inc;
    logic [26:0]        green_prod;
    logic [10:0]        green_full;
    logic [7:0]         green_sat;

    always_comb
    begin
        tick_inc = tick_reg + 8'd1;
        gust     = tick_inc > {1'b0, item_reg.gust_threshold};
        goal_sel = gust ? item_reg.gust_target : goal_reg;
        gap      = $signed({1'b0, goal_sel}) - $signed({1'b0, global_reg});
        gap_neg  = -gap;

        tgt_sum  = $signed({2'b00, global_reg})
                 + $signed({{4{item_reg.variation[5]}}, item_reg.variation});
        flame_lo = $signed({2'b00, flame_floor_reg});
        flame_hi = $signed({2'b00, flame_ceiling_reg});
        if (tgt_sum < flame_lo)
            tgt = flame_floor_reg;
        else if (tgt_sum > flame_hi)
            tgt = flame_ceiling_reg;
        else
            tgt = tgt_sum[7:0];
        // 3 * filtered + target, then / 4
        b_sum = {1'b0, filtered_reg, 1'b0} + {2'b00, filtered_reg} + {2'b00, tgt};

        q_prod = 16'(abs_reg) * RECIP_DIV10;
        case (speed_reg)
            SPEED_DIV10: q_full = q_prod >> 11;
            SPEED_DIV8:  q_full = 16'(abs_reg) >> 3;
            SPEED_DIV6:  q_full = (16'(abs_reg) * RECIP_DIV6) >> 10;
            SPEED_DIV4:  q_full = 16'(abs_reg) >> 2;
            default:     q_full = q_prod >> 11;
        endcase
        hue_factor = (item_reg.hue < HUE_SPLIT) ? item_reg.hue : item_reg.hue - HUE_SPLIT;
        white_prod = 16'(b_reg) * RECIP_WHITE;

        step_val = neg_reg ? -$signed({5'b0, q_reg}) : $signed({5'b0, q_reg});
        g_sum    = $signed({3'b000, global_reg}) + step_val
                 + $signed({{9{item_reg.noise[1]}}, item_reg.noise});
        glow_lo  = $signed({3'b000, glow_floor_reg});
        glow_hi  = $signed({3'b000, glow_ceiling_reg});
        if (g_sum < glow_lo)
            g_new = glow_floor_reg;
        else if (g_sum > glow_hi)
            g_new = glow_ceiling_reg;
        else
            g_new = g_sum[7:0];
        dim_limit = {1'b0, glow_floor_reg} + DIM_MARGIN;
        calm_inc  = calm_reg + 7'd1;

        if (low_hue_reg)
            green_prod = (27'(prod_reg) * RECIP_LOW) >> 16;
        else
            green_prod = (27'(prod_reg) * RECIP_HIGH) >> 17;
        green_full = green_prod[10:0];
        green_sat  = (green_full > 11'd255) ? 8'd255 : green_full[7:0];

        global_next   = global_reg;
        filtered_next = filtered_reg;
        goal_next     = goal_reg;
        speed_next    = speed_reg;
        tick_next     = tick_reg;
        calm_next     = calm_reg;
        abs_next      = abs_reg;
        neg_next      = neg_reg;
        b_next        = b_reg;
        q_next        = q_reg;
        prod_next     = prod_reg;
        white_next    = white_reg;
        low_hue_next  = low_hue_reg;
        res_next      = res_reg;

        if (cmd.step1)
        begin
            if (item_reg.kind == KIND_WIND)
            begin
                tick_next = gust ? 8'd0 : tick_inc;
                if (gust)
                begin
                    goal_next  = item_reg.gust_target;
                    speed_next = item_reg.gust_speed;
                end
                neg_next = gap[8];
                abs_next = gap[8] ? gap_neg[7:0] : gap[7:0];
            end
            else
            begin
                b_next        = b_sum[9:2];
                filtered_next = b_sum[9:2];
            end
        end

        if (cmd.step2)
        begin
            q_next       = q_full[5:0];
            prod_next    = 13'(hue_factor) * 13'(b_reg);
            low_hue_next = item_reg.hue < HUE_SPLIT;
            white_next   = white_prod[15:8] >> 4;
        end

        if (cmd.commit)
        begin
            if (item_reg.kind == KIND_WIND)
            begin
                global_next = g_new;
                if ({1'b0, g_new} < dim_limit)
                begin
                    if (calm_inc > CALM_LIMIT)
                    begin
                        calm_next = 7'd0;
                        goal_next = item_reg.recover_target;
                    end
                    else
                    begin
                        calm_next = calm_inc;
                    end
                end
                else if (calm_reg != 7'd0)
                begin
                    calm_next = calm_reg - 7'd1;
                end
                res_next = '{red: 8'd0, green: 8'd0, white: 8'd0, level: g_new,
                             frame_end: 1'b0};
            end
            else
            begin
                res_next = '{red: b_reg, green: green_sat, white: white_reg,
                             level: b_reg, frame_end: item_reg.last_pixel};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flame_floor_reg   <= RST_FLAME_FLOOR;
            flame_ceiling_reg <= RST_FLAME_CEILING;
            glow_floor_reg    <= RST_GLOW_FLOOR;
            glow_ceiling_reg  <= RST_GLOW_CEILING;
            global_reg        <= RST_LEVEL;
            filtered_reg      <= RST_LEVEL;
            goal_reg          <= RST_LEVEL;
            speed_reg         <= RST_SPEED;
            tick_reg          <= 8'd0;
            calm_reg          <= 7'd0;
        end
        else
        begin
            global_reg   <= global_next;
            filtered_reg <= filtered_next;
            goal_reg     <= goal_next;
            speed_reg    <= speed_next;
            tick_reg     <= tick_next;
            calm_reg     <= calm_next;
            if (cfg_wr.we)
            begin
                case (cfg_wr.index)
                    CFG_FLAME_FLOOR:   flame_floor_reg   <= cfg_wr.data;
                    CFG_FLAME_CEILING: flame_ceiling_reg <= cfg_wr.data;
                    CFG_GLOW_FLOOR:    glow_floor_reg    <= cfg_wr.data;
                    CFG_GLOW_CEILING:  glow_ceiling_reg  <= cfg_wr.data;
                    default:           ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
            item_reg <= item_in;
        abs_reg     <= abs_next;
        neg_reg     <= neg_next;
        b_reg       <= b_next;
        q_reg       <= q_next;
        prod_reg    <= prod_next;
        white_reg   <= white_next;
        low_hue_reg <= low_hue_next;
        res_reg     <= res_next;
    end

    assign result_out = res_reg;

endmodule

// File: design/flame_flicker_pixel_engine.sv
// ----------------------------------------------------------------------------
// flame_flicker_pixel_engine
// Candle-flame LED colour generator: wind ticks and pixel colour requests.
// ----------------------------------------------------------------------------
// a result enters the output register at the commit step after its request is accepted
// a new request is accepted only after the previous one has passed the accept state and the
//   three-step datapath sequence (gap or target, reciprocal multiply, clamp and commit)
// a result waiting in the output register stalls only the commit step
// reset: asynchronous, loads flame state start values and register defaults
module flame_flicker_pixel_engine (
    input logic         clk,
    input logic         rst_n,
    ffp_item_if.sink    item,
    ffp_result_if.source result,
    ffp_cfg_if.sink     cfg
);
    import ffp_pkg::*;

    ctrl_cmd_t cmd;
    in_item_t  item_in;
    out_item_t result_out;
    cfg_wr_t   cfg_wr;

    assign item_in = '{kind: item.kind, hue: item.hue, variation: item.variation,
                       gust_threshold: item.gust_threshold,
                       gust_target: item.gust_target, gust_speed: item.gust_speed,
                       noise: item.noise, recover_target: item.recover_target,
                       last_pixel: item.last_pixel};

    assign cfg.ready = 1'b1;
    assign cfg_wr    = '{we: cfg.valid, index: cfg.index, data: cfg.data};

    ffp_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (item.valid),
        .in_ready  (item.ready),
        .out_valid (result.valid),
        .out_ready (result.ready),
        .cmd       (cmd)
    );

    ffp_dp u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .item_in    (item_in),
        .cfg_wr     (cfg_wr),
        .result_out (result_out)
    );

    assign result.red       = result_out.red;
    assign result.green     = result_out.green;
    assign result.white     = result_out.white;
    assign result.level     = result_out.level;
    assign result.frame_end = result_out.frame_end;

endmodule

// File: design/ffp_checker.sv
// ----------------------------------------------------------------------------
// ffp_checker
// Port-level checks of the flame flicker pixel engine, bound to the top level.
// ----------------------------------------------------------------------------
module ffp_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       item_valid,
    input logic       item_ready,
    input logic       result_valid,
    input logic       result_ready,
    input logic [7:0] red,
    input logic [7:0] green,
    input logic [7:0] white,
    input logic [7:0] level,
    input logic       frame_end
);

    // a request keeps the engine busy for its working steps
    assert property (@(posedge clk) disable iff (!rst_n)
        (item_valid && item_ready) |=> !item_ready ##1 !item_ready)
        else $error("engine took a request while still working");

    // a new result only appears at the end of a working sequence
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> !$past(item_ready))
        else $error("result appeared without a request in progress");

    // wind results are blank, pixel results tie red and white to level
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> ((red == 8'd0 && green == 8'd0 && white == 8'd0 && !frame_end)
                          || (red == level && white == level / 8'd20)))
        else $error("result fields inconsistent");

    // stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !result_ready) |=>
            (result_valid && $stable(red) && $stable(green) && $stable(white)
             && $stable(level) && $stable(frame_end)))
        else $error("stalled result changed");

endmodule

bind flame_flicker_pixel_engine ffp_checker u_ffp_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_valid   (item.valid),
    .item_ready   (item.ready),
    .result_valid (result.valid),
    .result_ready (result.ready),
    .red          (result.red),
    .green        (result.green),
    .white        (result.white),
    .level        (result.level),
    .frame_end    (result.frame_end)
);

// File: bench/tb_flame_flicker_pixel_engine.sv
// ----------------------------------------------------------------------------
// tb_flame_flicker_pixel_engine
// Self-checking bench for the flame flicker pixel engine. A scoreboard keeps
// its own copy of the flame state and registers, predicts every result as
// requests are accepted and compares each returned result field by field.
// Directed corner requests come first, then randomized phases with different
// register settings, handshake idling and a long output stall.
// ----------------------------------------------------------------------------
module tb_flame_flicker_pixel_engine;
    timeunit 1ns;
    timeprecision 1ps;

    import ffp_pkg::*;

    localparam int WHITE_DIV    = 20;
    localparam int LOW_HUE_DIV  = 20;
    localparam int HIGH_HUE_DIV = 15;
    localparam int SETTLE_CYCLES = 8;
    localparam int STALL_CYCLES  = 80;

    // indexes that decode to no register
    localparam logic [7:0] CFG_UNUSED_LOW = 8'd4;
    localparam logic [7:0] CFG_UNUSED_TOP = 8'hFF;

    class flame_scoreboard;
        logic [7:0] flame_floor, flame_ceiling, glow_floor, glow_ceiling;
        logic [7:0] glow_level, smooth_level, gust_goal, tick_cnt;
        logic [1:0] speed;
        logic [6:0] calm_cnt;
        out_item_t  expected_colors[$];
        int         mismatches;

        function new();
            flame_floor   = RST_FLAME_FLOOR;
            flame_ceiling = RST_FLAME_CEILING;
            glow_floor    = RST_GLOW_FLOOR;
            glow_ceiling  = RST_GLOW_CEILING;
            glow_level    = RST_LEVEL;
            smooth_level  = RST_LEVEL;
            gust_goal     = RST_LEVEL;
            speed         = RST_SPEED;
            tick_cnt      = '0;
            calm_cnt      = '0;
            mismatches    = 0;
        endfunction

        function int pending();
            return expected_colors.size();
        endfunction

        function void write_reg(logic [7:0] idx, logic [7:0] val);
            case (idx)
                CFG_FLAME_FLOOR:   flame_floor   = val;
                CFG_FLAME_CEILING: flame_ceiling = val;
                CFG_GLOW_FLOOR:    glow_floor    = val;
                CFG_GLOW_CEILING:  glow_ceiling  = val;
                default: ;
            endcase
        endfunction

        // crossed bounds: values below the floor give the floor, all others the ceiling
        function int clamp_to(int x, int lo, int hi);
            if (x < lo)
                return lo;
            if (x > hi)
                return hi;
            return x;
        endfunction

        function void note_request(in_item_t req);
            int gap, divisor, g, target, b, green;
            out_item_t exp;
            exp = '0;
            if (req.kind == KIND_WIND)
            begin
                tick_cnt = tick_cnt + 8'd1;
                if (tick_cnt > {1'b0, req.gust_threshold})
                begin
                    tick_cnt  = '0;
                    gust_goal = req.gust_target;
                    speed     = req.gust_speed;
                end
                gap     = int'(gust_goal) - int'(glow_level);
                divisor = 10 - 2 * int'(speed);
                g = int'(glow_level) + gap / divisor;
                g = g + int'($signed(req.noise));
                g = clamp_to(g, int'(glow_floor), int'(glow_ceiling));
                glow_level = g[7:0];
                if (g < int'(glow_floor) + int'(DIM_MARGIN))
                begin
                    calm_cnt = calm_cnt + 7'd1;
                    // dim for too long: move the wind goal to the recovery target
                    if (calm_cnt > CALM_LIMIT)
                    begin
                        gust_goal = req.recover_target;
                        calm_cnt  = '0;
                    end
                end
                else if (calm_cnt != 0)
                begin
                    calm_cnt = calm_cnt - 7'd1;
                end
                exp.level = glow_level;
            end
            else
            begin
                target = clamp_to(int'(glow_level) + int'($signed(req.variation)),
                                  int'(flame_floor), int'(flame_ceiling));
                b = (3 * int'(smooth_level) + target) / 4;
                smooth_level = b[7:0];
                if (req.hue < HUE_SPLIT)
                    green = int'(req.hue) * b / LOW_HUE_DIV;
                else
                    green = (int'(req.hue) - int'(HUE_SPLIT)) * b / HIGH_HUE_DIV;
                if (green > 255)
                    green = 255;
                exp.red       = b[7:0];
                exp.green     = green[7:0];
                exp.white     = 8'(b / WHITE_DIV);
                exp.level     = b[7:0];
                exp.frame_end = req.last_pixel;
            end
            expected_colors.push_back(exp);
        endfunction

        function void check_result(out_item_t got);
            out_item_t exp;
            if (expected_colors.size() == 0)
            begin
                $error("result with no request pending: level %0d", got.level);
                mismatches++;
                return;
            end
            exp = expected_colors.pop_front();
            if (got.red !== exp.red)
            begin
                $error("red: expected %0d, got %0d", exp.red, got.red);
                mismatches++;
            end
            if (got.green !== exp.green)
            begin
                $error("green: expected %0d, got %0d", exp.green, got.green);
                mismatches++;
            end
            if (got.white !== exp.white)
            begin
                $error("white: expected %0d, got %0d", exp.white, got.white);
                mismatches++;
            end
            if (got.level !== exp.level)
            begin
                $error("level: expected %0d, got %0d", exp.level, got.level);
                mismatches++;
            end
            if (got.frame_end !== exp.frame_end)
            begin
                $error("frame_end: expected %0d, got %0d", exp.frame_end, got.frame_end);
                mismatches++;
            end
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n;

    ffp_item_if   item_ch();
    ffp_result_if res_ch();
    ffp_cfg_if    cfg_ch();

    flame_flicker_pixel_engine dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_ch),
        .result (res_ch),
        .cfg    (cfg_ch)
    );

    flame_scoreboard sb = new();

    int src_idle_pct  = 0;
    int sink_idle_pct = 0;
    int stall_asks    = 0;
    int stall_done    = 0;

    always #4 clk = ~clk;

    initial
    begin
        #2ms;
        $display("simulation failed");
        $finish;
    end

    // watch all three channels at the clock edge
    always @(posedge clk)
    begin : monitor
        in_item_t  req;
        out_item_t res;
        if (rst_n)
        begin
            if (cfg_ch.valid && cfg_ch.ready)
                sb.write_reg(cfg_ch.index, cfg_ch.data);
            if (res_ch.valid && res_ch.ready)
            begin
                res.red       = res_ch.red;
                res.green     = res_ch.green;
                res.white     = res_ch.white;
                res.level     = res_ch.level;
                res.frame_end = res_ch.frame_end;
                sb.check_result(res);
            end
            if (item_ch.valid && item_ch.ready)
            begin
                req.kind           = item_ch.kind;
                req.hue            = item_ch.hue;
                req.variation      = item_ch.variation;
                req.gust_threshold = item_ch.gust_threshold;
                req.gust_target    = item_ch.gust_target;
                req.gust_speed     = item_ch.gust_speed;
                req.noise          = item_ch.noise;
                req.recover_target = item_ch.recover_target;
                req.last_pixel     = item_ch.last_pixel;
                sb.note_request(req);
            end
        end
    end

    // result receiver, with a long hold-off on demand
    initial
    begin : receiver
        int hold;
        hold = 0;
        res_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (stall_asks != stall_done)
            begin
                stall_done++;
                hold = STALL_CYCLES;
            end
            if (hold > 0)
            begin
                hold--;
                res_ch.ready <= 1'b0;
            end
            else
            begin
                res_ch.ready <= ($urandom_range(99) >= sink_idle_pct);
            end
        end
    end

    function automatic in_item_t random_request(logic kind);
        in_item_t it;
        it.kind           = kind;
        it.hue            = ($urandom_range(0, 3) == 0) ? 5'($urandom) :
                                                          5'($urandom_range(0, 17));
        it.variation      = 6'($urandom);
        it.gust_threshold = ($urandom_range(0, 1) == 0) ? 7'($urandom_range(0, 15)) :
                                                          7'($urandom);
        it.gust_target    = 8'($urandom);
        it.gust_speed     = 2'($urandom);
        it.noise          = 2'($urandom);
        it.recover_target = 8'($urandom);
        it.last_pixel     = 1'($urandom);
        return it;
    endfunction

    task automatic send_request(in_item_t it);
        while ($urandom_range(99) < src_idle_pct)
        begin
            item_ch.valid <= 1'b0;
            @(posedge clk);
        end
        item_ch.valid          <= 1'b1;
        item_ch.kind           <= it.kind;
        item_ch.hue            <= it.hue;
        item_ch.variation      <= it.variation;
        item_ch.gust_threshold <= it.gust_threshold;
        item_ch.gust_target    <= it.gust_target;
        item_ch.gust_speed     <= it.gust_speed;
        item_ch.noise          <= it.noise;
        item_ch.recover_target <= it.recover_target;
        item_ch.last_pixel     <= it.last_pixel;
        @(posedge clk);
        while (!item_ch.ready)
            @(posedge clk);
    endtask

    task automatic send_pixel(logic [4:0] hue, logic signed [5:0] variation, logic last);
        in_item_t it;
        it = random_request(KIND_PIXEL);
        it.hue        = hue;
        it.variation  = variation;
        it.last_pixel = last;
        send_request(it);
    endtask

    task automatic send_wind(logic [6:0] thr, logic [7:0] goal, logic [1:0] spd,
                             logic signed [1:0] noise, logic [7:0] recover);
        in_item_t it;
        it = random_request(KIND_WIND);
        it.gust_threshold = thr;
        it.gust_target    = goal;
        it.gust_speed     = spd;
        it.noise          = noise;
        it.recover_target = recover;
        send_request(it);
    endtask

    // leaves valid high; the caller lowers it after the last write
    task automatic write_reg(logic [7:0] idx, logic [7:0] val);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
    endtask

    task automatic load_regs(logic [7:0] ff, logic [7:0] fc, logic [7:0] gf, logic [7:0] gc);
        write_reg(CFG_FLAME_FLOOR, ff);
        write_reg(CFG_FLAME_CEILING, fc);
        write_reg(CFG_GLOW_FLOOR, gf);
        write_reg(CFG_GLOW_CEILING, gc);
        cfg_ch.valid <= 1'b0;
        @(posedge clk);
    endtask

    // the first edge lets the monitor note the last accepted request
    task automatic drain();
        item_ch.valid <= 1'b0;
        do
            @(posedge clk);
        while (sb.pending() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic random_phase(int count);
        int sent, len, sel;
        in_item_t it;
        sent = 0;
        while (sent < count)
        begin
            sel = $urandom_range(0, 9);
            if (sel < 5)
            begin
                // a frame of pixels, normally closed by its last pixel
                len = $urandom_range(1, 8);
                for (int i = 0; i < len; i++)
                begin
                    it = random_request(KIND_PIXEL);
                    if ($urandom_range(0, 9) != 0)
                        it.last_pixel = (i == len - 1);
                    send_request(it);
                    sent++;
                end
            end
            else if (sel < 9)
            begin
                len = $urandom_range(1, 12);
                repeat (len)
                begin
                    send_request(random_request(KIND_WIND));
                    sent++;
                end
            end
            else
            begin
                send_request(random_request(1'($urandom)));
                sent++;
            end
        end
    endtask

    // low gust goals keep the flame dim long enough to trigger a recovery
    task automatic dim_stretch(int count);
        in_item_t it;
        repeat (count)
        begin
            it = random_request(KIND_WIND);
            it.gust_threshold = 7'($urandom_range(0, 3));
            it.gust_target    = 8'($urandom_range(0, 10));
            send_request(it);
        end
    endtask

    initial
    begin : stimulus
        logic [7:0] gf;
        rst_n                  <= 1'b0;
        item_ch.valid          <= 1'b0;
        item_ch.kind           <= KIND_WIND;
        item_ch.hue            <= '0;
        item_ch.variation      <= '0;
        item_ch.gust_threshold <= '0;
        item_ch.gust_target    <= '0;
        item_ch.gust_speed     <= '0;
        item_ch.noise          <= '0;
        item_ch.recover_target <= '0;
        item_ch.last_pixel     <= 1'b0;
        cfg_ch.valid           <= 1'b0;
        cfg_ch.index           <= CFG_FLAME_FLOOR;
        cfg_ch.data            <= '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // corner requests with the register defaults
        send_pixel(5'd0, -6'sd32, 1'b0);
        send_pixel(5'd31, 6'sd31, 1'b1);
        send_pixel(5'd9, 6'sd0, 1'b0);
        send_pixel(5'd10, -6'sd25, 1'b0);
        send_pixel(5'd17, 6'sd24, 1'b1);
        send_pixel(5'd18, 6'sd1, 1'b0);
        send_wind(7'd0, 8'd0, SPEED_DIV10, -2'sd2, 8'd255);
        send_wind(7'd127, 8'd128, SPEED_DIV6, -2'sd1, 8'd255);
        send_wind(7'd0, 8'd200, SPEED_DIV8, 2'sd0, 8'd0);
        repeat (6)
            send_wind(7'd0, 8'd255, SPEED_DIV4, 2'sd1, 8'd0);
        send_pixel(5'd31, 6'sd31, 1'b0);
        send_pixel(5'd31, 6'sd31, 1'b1);
        send_pixel(5'd15, -6'sd1, 1'b0);
        send_wind(7'd0, 8'd0, SPEED_DIV4, -2'sd2, 8'd0);
        send_pixel(5'd3, -6'sd32, 1'b1);
        drain();

        // widest ranges, slow sender, slower receiver
        load_regs(8'd0, 8'd255, 8'd0, 8'd255);
        src_idle_pct  = 12;
        sink_idle_pct = 67;
        random_phase(130);
        drain();

        // crossed bounds, plus writes to unused indexes
        write_reg(CFG_UNUSED_LOW, 8'($urandom));
        write_reg(CFG_UNUSED_TOP, 8'($urandom));
        load_regs(8'd255, 8'd0, 8'd200, 8'd120);
        src_idle_pct  = 67;
        sink_idle_pct = 12;
        random_phase(130);
        drain();

        // random settings at full rate, with a long output stall
        gf = 8'($urandom_range(60, 140));
        load_regs(8'($urandom), 8'($urandom), gf, gf + 8'($urandom_range(0, 100)));
        src_idle_pct  = 0;
        sink_idle_pct = 0;
        stall_asks++;
        random_phase(50);
        dim_stretch(110);
        random_phase(10);
        drain();

        if (sb.pending() != 0)
        begin
            $error("%0d expected results never arrived", sb.pending());
            sb.mismatches++;
        end
        if (sb.mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

// File: filelist.f
design/ffp_pkg.sv
design/ffp_if.sv
design/ffp_ctrl.sv
design/ffp_dp.sv
design/flame_flicker_pixel_engine.sv
design/ffp_checker.sv
bench/tb_flame_flicker_pixel_engine.sv
